// ===== src/wrm_pkg.sv =====
package wrm_pkg;

  localparam int unsigned DEF_TABLE_DEPTH         = 16384;
  localparam int unsigned DEF_PHASE_FRACTION_BITS = 16;

  // Field widths of the channels and the registers.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned TVAL_W   = 16;
  localparam int unsigned TADDR_W  = 14;
  localparam int unsigned START_W  = 14;
  localparam int unsigned END_W    = 15;
  localparam int unsigned STEP_W   = 32;

  // Phase arithmetic is carried in this width: a bound of up to 2^16 entries with
  // 16 fraction bits plus a 32-bit step still fits.
  localparam int unsigned ACC_W   = 34;
  // Width for comparing table entry counts and loop bounds.
  localparam int unsigned BOUND_W = 18;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned PRODUCT_DIVISOR = 32768;
  localparam int unsigned DIV_SHIFT       = $clog2(PRODUCT_DIVISOR);
  localparam int unsigned DIV_BIAS        = PRODUCT_DIVISOR - 1;
  localparam int unsigned PROD_W          = SAMPLE_W + TVAL_W;

  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned REG_INDEX_W = 2;

  localparam logic [REG_INDEX_W-1:0] REG_RING_STEP   = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_LOOP_START  = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_LOOP_END    = 2'd2;
  localparam logic [REG_INDEX_W-1:0] REG_CARRIER_END = 2'd3;

  localparam logic [END_W-1:0] RST_LOOP_END    = 15'd2;
  localparam logic [END_W-1:0] RST_CARRIER_END = 15'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef struct packed {
    logic [STEP_W-1:0]  ring_step;
    logic [START_W-1:0] loop_start;
    logic [END_W-1:0]   loop_end;
    logic [END_W-1:0]   carrier_loop_end;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] off;
    logic [ACC_W-1:0] lim;
    logic [ACC_W-1:0] span;
  } loop_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_BYPASS,
    KIND_MOD
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [SAMPLE_W-1:0] data;
    logic [TADDR_W-1:0]  addr;
  } item_t;

  typedef struct packed {
    logic rd_issue;
    logic rd_in_loop;
  } back_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP1,
    ST_WAIT1,
    ST_WRAP2,
    ST_WAIT2,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_CHECK,
    MS_RUN,
    MS_FIN
  } mod_state_t;

endpackage

// ===== src/wrm_ifs.sv =====
interface wrm_in_if;
  import wrm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic signed [SAMPLE_W-1:0] carrier_sample;
  logic [TADDR_W-1:0]         table_address;
  logic signed [TVAL_W-1:0]   table_value;

  modport source (output valid, opcode, carrier_sample, table_address, table_value,
                  input ready);
  modport sink (input valid, opcode, carrier_sample, table_address, table_value,
                output ready);
endinterface

interface wrm_out_if;
  import wrm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       bypassed;

  modport source (output valid, out_sample, bypassed, input ready);
  modport sink (input valid, out_sample, bypassed, output ready);
endinterface

// ===== src/wrm_front.sv =====
module wrm_front import wrm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH         = DEF_TABLE_DEPTH,
  parameter int unsigned PHASE_FRACTION_BITS = DEF_PHASE_FRACTION_BITS
) (
  wrm_in_if.sink      in_ch,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item,
  output loop_t       loop
);

  logic [BOUND_W-1:0] depth_b;
  logic [BOUND_W-1:0] start_c;
  logic [BOUND_W-1:0] end_lo;
  logic [BOUND_W-1:0] end_c;
  logic [ACC_W-1:0]   clim;
  logic [ACC_W-1:0]   step_w;
  logic               bypass;
  logic               addr_oob;
  logic               accept;

  assign depth_b = BOUND_W'(TABLE_DEPTH);

  // Loop bounds: the start is clamped into the table, then the end above the start
  // and at most the table depth.
  always_comb begin
    start_c = BOUND_W'(cfg.loop_start);
    if (start_c > depth_b - 1'b1) begin
      start_c = depth_b - 1'b1;
    end
    end_lo = BOUND_W'(cfg.loop_end);
    if (end_lo < start_c + 1'b1) begin
      end_lo = start_c + 1'b1;
    end
    end_c = (end_lo > depth_b) ? depth_b : end_lo;
  end

  assign loop.off  = ACC_W'(start_c) << PHASE_FRACTION_BITS;
  assign loop.lim  = ACC_W'(end_c) << PHASE_FRACTION_BITS;
  assign loop.span = loop.lim - loop.off;

  assign clim   = ACC_W'(cfg.carrier_loop_end) << PHASE_FRACTION_BITS;
  assign step_w = ACC_W'(cfg.ring_step);

  // A zero step, or one over half of either loop end (aliasing), passes the carrier.
  assign bypass = (cfg.ring_step == '0) || (step_w > (loop.lim >> 1))
               || (step_w > (clim >> 1));

  assign addr_oob = BOUND_W'(in_ch.table_address) >= depth_b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Writes beyond the table are dropped here and never reach the back end.
  assign q_push = accept && !((in_ch.opcode == OP_WRITE) && addr_oob);

  always_comb begin
    q_item.addr = in_ch.table_address;
    if (in_ch.opcode == OP_WRITE) begin
      q_item.kind = KIND_WRITE;
      q_item.data = SAMPLE_W'(in_ch.table_value);
    end else begin
      q_item.kind = bypass ? KIND_BYPASS : KIND_MOD;
      q_item.data = in_ch.carrier_sample;
    end
  end

endmodule

// ===== src/wrm_queue.sv =====
module wrm_queue import wrm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full  = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/wrm_mod.sv =====
module wrm_mod import wrm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] x,
  input  logic [ACC_W-1:0] off,
  input  logic [ACC_W-1:0] span,
  output logic             done,
  output logic [ACC_W-1:0] res
);

  localparam int unsigned CNT_W = $clog2(ACC_W + 1);

  mod_state_t       state_r;
  mod_state_t       state_nxt;
  logic [ACC_W-1:0] dvd_r;
  logic [ACC_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] diff;
  logic [ACC_W-1:0] rem_sh;
  logic             fast;

  // The phase has usually overrun the loop by less than one span, so one
  // subtraction settles it; otherwise a restoring remainder runs one bit a cycle.
  assign diff   = dvd_r - span;
  assign fast   = diff < span;
  assign rem_sh = {rem_r[ACC_W-2:0], dvd_r[ACC_W-1]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MS_IDLE:  if (start) state_nxt = MS_CHECK;
      MS_CHECK: state_nxt = fast ? MS_FIN : MS_RUN;
      MS_RUN:   if (cnt_r == CNT_W'(1)) state_nxt = MS_FIN;
      MS_FIN:   state_nxt = MS_IDLE;
      default:  state_nxt = MS_IDLE;
    endcase
  end

  always_comb begin
    done = state_r == MS_FIN;
    res  = rem_r + off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MS_IDLE: begin
        if (start) begin
          dvd_r <= x - off;
        end
      end
      MS_CHECK: begin
        rem_r <= fast ? diff : '0;
        cnt_r <= CNT_W'(ACC_W);
      end
      MS_RUN: begin
        rem_r <= (rem_sh >= span) ? rem_sh - span : rem_sh;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/wrm_back.sv =====
module wrm_back import wrm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH         = DEF_TABLE_DEPTH,
  parameter int unsigned PHASE_FRACTION_BITS = DEF_PHASE_FRACTION_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  loop_t             loop,
  input  logic [STEP_W-1:0] ring_step,
  input  logic              q_empty,
  input  item_t             q_head,
  output logic              q_pop,
  wrm_out_if.source         out_ch,
  output back_stat_t        stat
);

  localparam int unsigned TW = $clog2(TABLE_DEPTH);

  back_state_t                state_r;
  back_state_t                state_nxt;
  logic [ACC_W-1:0]           acc_r;
  logic [SAMPLE_W-1:0]        phase_r;
  logic signed [SAMPLE_W-1:0] carrier_r;
  logic [TVAL_W-1:0]          rd_data_r;
  logic [PROD_W-1:0]          prod_r;
  logic signed [PROD_W-1:0]   prod_s;
  logic [PROD_W-1:0]          biased;
  logic [TVAL_W-1:0]          quot;
  logic [SAMPLE_W-1:0]        res_r;
  logic                       byp_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_sample_r;
  logic                       out_byp_r;
  logic [TVAL_W-1:0]          wave_mem [TABLE_DEPTH];

  logic                       wrap_need;
  logic                       out_free;
  logic                       mem_we;
  logic                       rd_en;
  logic                       mod_start;
  logic                       mod_done;
  logic [ACC_W-1:0]           mod_res;
  logic                       load_out;

  assign wrap_need = acc_r >= loop.lim;
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.kind)
            KIND_BYPASS: state_nxt = ST_OUT;
            KIND_MOD:    state_nxt = ST_WRAP1;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRAP1: state_nxt = wrap_need ? ST_WAIT1 : ST_WRAP2;
      ST_WAIT1: if (mod_done) state_nxt = ST_WRAP1;
      ST_WRAP2: state_nxt = wrap_need ? ST_WAIT2 : ST_READ;
      ST_WAIT2: if (mod_done) state_nxt = ST_WRAP2;
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == ST_IDLE) && !q_empty;
    mem_we    = q_pop && (q_head.kind == KIND_WRITE);
    mod_start = ((state_r == ST_WRAP1) || (state_r == ST_WRAP2)) && wrap_need;
    rd_en     = state_r == ST_READ;
    load_out  = (state_r == ST_OUT) && out_free;
  end

  wrm_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .x     (acc_r),
    .off   (loop.off),
    .span  (loop.span),
    .done  (mod_done),
    .res   (mod_res)
  );

  // Signed 16 x 32 product; the quotient by 32768 rounds toward zero, so a
  // negative product is biased before the shift.
  assign prod_s = $signed(rd_data_r) * carrier_r;
  assign biased = prod_r + (prod_r[PROD_W-1] ? PROD_W'(DIV_BIAS) : PROD_W'(0));
  assign quot   = biased[DIV_SHIFT +: TVAL_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (rd_en) begin
        phase_r <= acc_r[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      carrier_r <= q_head.data;
      res_r     <= q_head.data;
      byp_r     <= 1'b1;
      acc_r     <= ACC_W'(phase_r);
    end
    if ((state_r == ST_WRAP1) && !wrap_need) begin
      acc_r <= acc_r + ACC_W'(ring_step);
    end
    if (((state_r == ST_WAIT1) || (state_r == ST_WAIT2)) && mod_done) begin
      acc_r <= mod_res;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_s;
    end
    if (state_r == ST_DIV) begin
      res_r <= {{(SAMPLE_W - TVAL_W){quot[TVAL_W-1]}}, quot};
      byp_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wave_mem[TW'(q_head.addr)] <= q_head.data[TVAL_W-1:0];
    end
    if (rd_en) begin
      rd_data_r <= wave_mem[TW'(acc_r >> PHASE_FRACTION_BITS)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= res_r;
      out_byp_r    <= byp_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = out_sample_r;
  assign out_ch.bypassed   = out_byp_r;

  assign stat.rd_issue   = rd_en;
  assign stat.rd_in_loop = acc_r < loop.lim;

endmodule

// ===== src/wavetable_ring_modulator.sv =====
// Wavetable ring modulator. Requests arrive on in_ch (valid/ready): opcode 0 carries
// a carrier sample, opcode 1 loads one wavetable entry. Each sample request gives one
// request on out_ch with the modulated sample or, when the step is zero or too large
// for either loop, the carrier itself with bypassed set. Table writes give nothing.
// Registers (ring_step, loop_start, loop_end, carrier_loop_end) sit on the APB port
// at byte addresses 0, 4, 8 and 12 and are to be written only while the block is
// idle, which the block does not enforce. A two-entry queue sits between the input
// classifier and the sequencer, so input is taken while a result waits on out_ch.
// The sequencer writes the table on pop, sends a bypassed sample straight out and
// takes a modulated sample through wrap, step, wrap, read, multiply, divide and
// output. Each reduction of the phase into the loop takes one subtraction when it
// overran by less than one span, else the bit-serial remainder. The table memory
// allows one write or one read a cycle. Reset sets the registers to 0, 0, 2 and 2
// and clears the phase and the queue; table contents stay undefined until written.
// A stalled out_ch holds its result while the queue fills, then in_ch.ready drops.
module wavetable_ring_modulator import wrm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH         = DEF_TABLE_DEPTH,
  parameter int unsigned PHASE_FRACTION_BITS = DEF_PHASE_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  wrm_in_if.sink             in_ch,
  wrm_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t                   cfg_r;
  logic [REG_INDEX_W-1:0] reg_idx;
  logic                   reg_we;
  loop_t                  loop;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  item_t                  q_item;
  item_t                  q_head;
  back_stat_t             back_stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_step        <= '0;
      cfg_r.loop_start       <= '0;
      cfg_r.loop_end         <= RST_LOOP_END;
      cfg_r.carrier_loop_end <= RST_CARRIER_END;
    end else if (reg_we) begin
      unique case (reg_idx)
        REG_RING_STEP:   cfg_r.ring_step        <= pwdata;
        REG_LOOP_START:  cfg_r.loop_start       <= pwdata[START_W-1:0];
        REG_LOOP_END:    cfg_r.loop_end         <= pwdata[END_W-1:0];
        REG_CARRIER_END: cfg_r.carrier_loop_end <= pwdata[END_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RING_STEP:   prdata = cfg_r.ring_step;
      REG_LOOP_START:  prdata = PDATA_W'(cfg_r.loop_start);
      REG_LOOP_END:    prdata = PDATA_W'(cfg_r.loop_end);
      REG_CARRIER_END: prdata = PDATA_W'(cfg_r.carrier_loop_end);
      default:         prdata = '0;
    endcase
  end

  wrm_front #(
    .TABLE_DEPTH         (TABLE_DEPTH),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item),
    .loop   (loop)
  );

  wrm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  wrm_back #(
    .TABLE_DEPTH         (TABLE_DEPTH),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .loop      (loop),
    .ring_step (cfg_r.ring_step),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ch    (out_ch),
    .stat      (back_stat)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("request popped from an empty queue");

  a_read_inside_loop: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.rd_issue |-> back_stat.rd_in_loop)
    else $error("table read with the phase outside the loop");

endmodule
